// ===== rtl/core/pnse_pkg.sv =====
// Package for the Perlin noise slice evaluator: types, codes and helpers.
// No dependencies; used by the top level, pnse_ctrl, pnse_dp and the testbench.
package pnse_pkg;

	localparam int FRAC_W = 16;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FADE1,
		ST_FADE2,
		ST_FADE3,
		ST_FADE4,
		ST_HASH1,
		ST_HASH2,
		ST_HASH3,
		ST_LERP_X,
		ST_LERP_Y,
		ST_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic fade1;
		logic fade2;
		logic fade3;
		logic fade4;
		logic hash1;
		logic hash2;
		logic hash3;
		logic lerp_x;
		logic lerp_y;
		logic out_load;
	} pnse_cmd_t;

	// Gradient for 2D slice, result is 19 bits signed
	function automatic logic signed [18:0] grad_xy(input logic [3:0] h,
		input logic signed [17:0] x, input logic signed [17:0] y);
		logic signed [18:0] a;
		logic signed [18:0] b;
		a = (h < 4'd8) ? 19'(x) : 19'(y);
		if (h < 4'd4)
			b = 19'(y);
		else if (h == 4'd12 || h == 4'd14)
			b = 19'(x);
		else
			b = '0;
		if (h[0]) a = -a;
		if (h[1]) b = -b;
		return a + b;
	endfunction

endpackage

// ===== rtl/core/perlin_noise_slice_eval_core.sv =====
// Channel   Signals                                             Dir
// request   valid/ready, func, entry_index, entry_value, x/y    in
// result    out_valid/out_ready, noise_value                    out
//
// A load request writes the table and leaves the controller idle. An
// evaluate request reaches the result register after four fade steps,
// three chained table reads, two blends and the output load; the next
// request is taken in the cycle after that load. One request is worked
// on at a time; a held result stalls a finished evaluate in its last step,
// in_ready low, until taken. Reset clears control.
// Top level of the noise evaluator; depends on pnse_pkg, pnse_ctrl, pnse_dp.
module perlin_noise_slice_eval_core
	import pnse_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_value,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);

	pnse_cmd_t cmd;
	logic signed [15:0] result;
	logic out_valid_q;

	pnse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_func(func),
		.in_ready(in_ready), .out_busy(out_valid_q && !out_ready), .cmd(cmd)
	);

	pnse_dp #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
		.clk(clk), .cmd(cmd), .in_func(func), .entry_index(entry_index),
		.entry_value(entry_value), .x_coord(x_coord), .y_coord(y_coord),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			noise_value <= result;
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/pnse_ctrl.sv =====
// Controller state machine for the noise evaluator.
// Depends on pnse_pkg.
module pnse_ctrl
	import pnse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_func,
	output logic      in_ready,
	input  logic      out_busy,
	output pnse_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (in_func == FUNC_EVAL)
						state_d = ST_FADE1;
				end
			end
			ST_FADE1: begin cmd.fade1 = 1'b1; state_d = ST_FADE2; end
			ST_FADE2: begin cmd.fade2 = 1'b1; state_d = ST_FADE3; end
			ST_FADE3: begin cmd.fade3 = 1'b1; state_d = ST_FADE4; end
			ST_FADE4: begin cmd.fade4 = 1'b1; state_d = ST_HASH1; end
			ST_HASH1: begin cmd.hash1 = 1'b1; state_d = ST_HASH2; end
			ST_HASH2: begin cmd.hash2 = 1'b1; state_d = ST_HASH3; end
			ST_HASH3: begin cmd.hash3 = 1'b1; state_d = ST_LERP_X; end
			ST_LERP_X: begin cmd.lerp_x = 1'b1; state_d = ST_LERP_Y; end
			ST_LERP_Y: begin cmd.lerp_y = 1'b1; state_d = ST_OUT; end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/pnse_dp.sv =====
// Datapath: permutation memory, fade, hash lookups, gradients and blends.
// Depends on pnse_pkg.
module pnse_dp
	import pnse_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic               clk,
	input  pnse_cmd_t          cmd,
	input  logic               in_func,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_value,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic signed [15:0] result
);

	logic [7:0] perm_mem [256];

	// four read ports are made from two memories holding identical copies
	logic [7:0] perm_b [256];
	logic [7:0] ix_q, iy_q;
	logic [15:0] ux_q, uy_q;
	logic [7:0] ra0, ra1, rb0, rb1;
	logic [7:0] rd0_q, rd1_q, rd2_q, rd3_q;
	logic [7:0] p0_q, p1_q, p2_q, p3_q;

	// fade working registers, x and y handled in parallel by two units
	logic [19:0] qx_q, qy_q;
	logic [16:0] u2x_q, u2y_q, u3x_q, u3y_q, fx_q, fy_q;
	logic signed [18:0] lx1_q, lx2_q;

	// read addresses by phase: cells, then cell hash plus row, then the last lookup
	always_comb begin
		ra0 = ix_q; ra1 = ix_q + 8'd1; rb0 = ix_q; rb1 = ix_q + 8'd1;
		if (cmd.hash1) begin
			ra0 = rd0_q + iy_q;
			ra1 = rd1_q + iy_q;
			rb0 = rd0_q + iy_q + 8'd1;
			rb1 = rd1_q + iy_q + 8'd1;
		end else if (cmd.hash2) begin
			ra0 = rd0_q; ra1 = rd1_q; rb0 = rd2_q; rb1 = rd3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in && in_func == FUNC_LOAD) begin
			perm_mem[entry_index] <= entry_value;
			perm_b[entry_index]   <= entry_value;
		end
		rd0_q <= perm_mem[ra0];
		rd1_q <= perm_mem[ra1];
		rd2_q <= perm_b[rb0];
		rd3_q <= perm_b[rb1];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ix_q <= 8'(x_coord >>> COORD_FRAC_BITS);
			iy_q <= 8'(y_coord >>> COORD_FRAC_BITS);
			if (COORD_FRAC_BITS >= FRAC_W) begin
				ux_q <= 16'(x_coord >> (COORD_FRAC_BITS - FRAC_W));
				uy_q <= 16'(y_coord >> (COORD_FRAC_BITS - FRAC_W));
			end else begin
				ux_q <= 16'(x_coord << (FRAC_W - COORD_FRAC_BITS));
				uy_q <= 16'(y_coord << (FRAC_W - COORD_FRAC_BITS));
			end
		end
	end

	// corner hashes land in the read registers after the third lookup
	always_ff @(posedge clk) begin
		if (cmd.hash3) begin
			p0_q <= rd0_q;
			p1_q <= rd1_q;
			p2_q <= rd2_q;
			p3_q <= rd3_q;
		end
	end

	// fade: fade1 to fade3 compute registered partial results; fade4 is unused here
	function automatic logic [16:0] rnd16(input logic [33:0] v);
		return 17'((v + 34'd32768) >> 16);
	endfunction

	logic [34:0] qxm, qym;
	always_comb begin
		// (10*2^32 + 6u^2 - 15*2^16 u + 2^15)>>16 = 10*2^16 + (6u^2 + 2^15)>>16 - 15u
		qxm = 35'(ux_q) * 35'(ux_q) * 35'd6;
		qym = 35'(uy_q) * 35'(uy_q) * 35'd6;
	end

	always_ff @(posedge clk) begin
		if (cmd.fade1) begin
			u2x_q <= rnd16(34'(ux_q) * 34'(ux_q));
			u2y_q <= rnd16(34'(uy_q) * 34'(uy_q));
			qx_q  <= 20'd655360 + 20'((qxm + 35'd32768) >> 16) - 20'(15 * 20'(ux_q));
			qy_q  <= 20'd655360 + 20'((qym + 35'd32768) >> 16) - 20'(15 * 20'(uy_q));
		end
		if (cmd.fade2) begin
			u3x_q <= rnd16(34'(u2x_q) * 34'(ux_q));
			u3y_q <= rnd16(34'(u2y_q) * 34'(uy_q));
		end
		if (cmd.fade3) begin
			fx_q <= rnd16(34'(u3x_q) * 34'(qx_q));
			fy_q <= rnd16(34'(u3y_q) * 34'(qy_q));
		end
	end

	// gradients and blends
	logic signed [17:0] dx0, dx1, dy0, dy1;
	logic signed [18:0] gv0, gv1, gv2, gv3;
	logic signed [20:0] dlt0, dlt1, dlty;
	logic signed [38:0] pr0, pr1, pry;
	logic signed [18:0] ly;
	always_comb begin
		dx0 = 18'(ux_q);
		dx1 = 18'(ux_q) - 18'sd65536;
		dy0 = 18'(uy_q);
		dy1 = 18'(uy_q) - 18'sd65536;
		gv0 = grad_xy(p0_q[3:0], dx0, dy0);
		gv1 = grad_xy(p1_q[3:0], dx1, dy0);
		gv2 = grad_xy(p2_q[3:0], dx0, dy1);
		gv3 = grad_xy(p3_q[3:0], dx1, dy1);
		dlt0 = 21'(gv1) - 21'(gv0);
		dlt1 = 21'(gv3) - 21'(gv2);
		pr0 = 39'(dlt0) * 39'($signed({1'b0, fx_q})) + 39'sd32768;
		pr1 = 39'(dlt1) * 39'($signed({1'b0, fx_q})) + 39'sd32768;
		dlty = 21'(lx2_q) - 21'(lx1_q);
		pry = 39'(dlty) * 39'($signed({1'b0, fy_q})) + 39'sd32768;
		ly = 19'(21'(lx1_q) + 21'(pry >>> 16));
	end

	logic signed [18:0] l_q;
	always_ff @(posedge clk) begin
		if (cmd.lerp_x) begin
			lx1_q <= 19'(21'(gv0) + 21'(pr0 >>> 16));
			lx2_q <= 19'(21'(gv2) + 21'(pr1 >>> 16));
		end
		if (cmd.lerp_y)
			l_q <= ly;
	end

	logic signed [18:0] rs;
	always_comb begin
		rs = (l_q + 19'sd2) >>> 2;
		if (rs > 19'sd32767)
			result = 16'sh7fff;
		else if (rs < -19'sd32768)
			result = 16'sh8000;
		else
			result = 16'(rs);
	end

	logic unused_ok;
	assign unused_ok = ^{cmd.fade4, cmd.out_load};

endmodule

// ===== rtl/core/pnse_checker.sv =====
// Port-level checker for the noise evaluator, bound to the top level.
// Depends on perlin_noise_slice_eval_core.
module pnse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] noise_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise_value))
		else $error("result dropped while stalled");

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while requests were being taken");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid in reset");

endmodule

bind perlin_noise_slice_eval_core pnse_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
);

// ===== tb/sv/perlin_noise_slice_eval_core_chk.sv =====
// Checker for the Perlin noise slice evaluator: watches both channels, keeps its own
// copy of the permutation table and predicts each noise value. Depends on pnse_pkg.
`timescale 1ns / 100ps
module perlin_noise_slice_eval_core_chk
	import pnse_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               func,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_value,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] noise_value,
	output int                 fail_count,
	output int                 pending,
	output int                 noise_seen
);
	logic [7:0] perm_copy [256];
	logic signed [15:0] noise_q [$];

	function automatic logic [15:0] frac_of(logic [31:0] c);
		if (COORD_FRAC_BITS >= 16)
			return 16'(c >> (COORD_FRAC_BITS - 16));
		return 16'((c & ((32'd1 << COORD_FRAC_BITS) - 1)) << (16 - COORD_FRAC_BITS));
	endfunction

	function automatic longint quintic(logic [15:0] u);
		longint unsigned uu, q, u2, u3;
		uu = u;
		q = (64'd10 << 32) + 6 * uu * uu - 64'd15 * 65536 * uu + 32768;
		q = q >> 16;
		u2 = (uu * uu + 32768) >> 16;
		u3 = (u2 * uu + 32768) >> 16;
		return longint'((u3 * q + 32768) >> 16);
	endfunction

	function automatic longint blend(longint t, longint a, longint b);
		return a + ((b - a) * t + 32768 >>> 16);
	endfunction

	function automatic longint slope(logic [7:0] h8, longint x, longint y);
		logic [3:0] h;
		longint a, b;
		h = h8[3:0];
		a = (h < 8) ? x : y;
		if (h < 4)
			b = y;
		else if (h == 12 || h == 14)
			b = x;
		else
			b = 0;
		if (h[0]) a = -a;
		if (h[1]) b = -b;
		return a + b;
	endfunction

	function automatic logic [7:0] hash_at(logic [7:0] cx, logic [7:0] cy);
		logic [7:0] a;
		a = perm_copy[cx] + cy;
		return perm_copy[perm_copy[a]];
	endfunction

	function automatic logic signed [15:0] noise_at(logic [31:0] xc, logic [31:0] yc);
		logic [7:0] ix, iy;
		longint fx, fy, tx, ty, l1, l2, l, r;
		ix = 8'(xc >> COORD_FRAC_BITS);
		iy = 8'(yc >> COORD_FRAC_BITS);
		fx = frac_of(xc);
		fy = frac_of(yc);
		tx = quintic(fx[15:0]);
		ty = quintic(fy[15:0]);
		l1 = blend(tx, slope(hash_at(ix, iy), fx, fy),
			slope(hash_at(ix + 8'd1, iy), fx - 65536, fy));
		l2 = blend(tx, slope(hash_at(ix, iy + 8'd1), fx, fy - 65536),
			slope(hash_at(ix + 8'd1, iy + 8'd1), fx - 65536, fy - 65536));
		l = blend(ty, l1, l2);
		r = (l + 2) >>> 2;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && out_valid && out_ready) begin
			noise_seen <= noise_seen + 1;
			if (noise_q.size() == 0) begin
				fail_count <= fail_count + 1;
				if (fail_count < 10)
					$display("unexpected noise result %0d", noise_value);
			end else begin
				want = noise_q.pop_front();
				if (want !== noise_value) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("noise mismatch: expected %0d got %0d", want, noise_value);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			if (func_t'(func) == FUNC_LOAD)
				perm_copy[entry_index] = entry_value;
			else
				noise_q.push_back(noise_at(x_coord, y_coord));
		end
		pending <= noise_q.size();
	end

	initial begin
		fail_count = 0;
		noise_seen = 0;
		pending = 0;
	end
endmodule

// ===== tb/sv/perlin_noise_slice_eval_core_tb.sv =====
// Top of the noise evaluator testbench: clock, reset, request stimulus and verdict.
// Depends on pnse_pkg, perlin_noise_slice_eval_core and perlin_noise_slice_eval_core_chk.
`timescale 1ns / 100ps
module perlin_noise_slice_eval_core_tb;
	import pnse_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = FUNC_LOAD;
	logic [7:0] entry_index = '0;
	logic [7:0] entry_value = '0;
	logic signed [31:0] x_coord = '0;
	logic signed [31:0] y_coord = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] noise_value;
	int fail_count, pending, noise_seen;
	int loads_sent, evals_sent;
	int burst_left = 0;
	int stall_mode = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	perlin_noise_slice_eval_core dut (.*);

	perlin_noise_slice_eval_core_chk chk (.*);

	// result side: phases of no stall, light and heavy stalls
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= ($urandom_range(0, 3) != 0);
		default: out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	task automatic send_request(logic f, logic [7:0] idx, logic [7:0] val,
		logic [31:0] xc, logic [31:0] yc);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		entry_index <= idx;
		entry_value <= val;
		x_coord <= xc;
		y_coord <= yc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (f == FUNC_LOAD) loads_sent++;
		else evals_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
		0: return $urandom();
		1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
		2: return {16'($urandom_range(0, 3)), 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0)};
		default: return {$urandom_range(0, 1) ? 16'h8000 : 16'h7FFF, 16'($urandom())};
		endcase
	endfunction

	initial begin
		logic [31:0] edge_pts [8];
		edge_pts = '{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h0000FFFF, 32'h00010000, 32'hFFFF0000, 32'h00FF8000};
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// whole table before any evaluate, so no unwritten entry is read
		for (int i = 0; i < 256; i++)
			send_request(FUNC_LOAD, 8'(i), 8'(255 - i), $urandom(), $urandom());
		for (int i = 0; i < 8; i++)
			send_request(FUNC_EVAL, 8'($urandom()), 8'($urandom()), edge_pts[i],
				edge_pts[7 - i]);
		for (int i = 0; i < 8; i++)
			send_request(FUNC_EVAL, 8'hFF, 8'hFF, edge_pts[i], edge_pts[i]);
		send_request(FUNC_LOAD, 8'hFF, 8'h00, 32'hFFFFFFFF, 32'h0);
		send_request(FUNC_LOAD, 8'h00, 8'hFF, 32'h0, 32'hFFFFFFFF);
		drain_results();
		for (int n = 0; n < 1400; n++) begin
			if ($urandom_range(0, 4) == 0)
				send_request(FUNC_LOAD, 8'($urandom()), 8'($urandom()), $urandom(),
					$urandom());
			else
				send_request(FUNC_EVAL, 8'($urandom()), 8'($urandom()), rand_coord(),
					rand_coord());
			if (n == 700) drain_results();
		end
		drain_results();
		repeat (30) @(posedge clk);
		$display("sent %0d table loads and %0d noise evaluations, %0d results checked",
			loads_sent, evals_sent, noise_seen);
		if (fail_count == 0)
			$display("perlin_noise_slice_eval_core verification clean");
		else
			$display("perlin_noise_slice_eval_core verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("perlin_noise_slice_eval_core verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/pnse_pkg.sv
rtl/core/pnse_ctrl.sv
rtl/core/pnse_dp.sv
rtl/core/perlin_noise_slice_eval_core.sv
rtl/core/pnse_checker.sv
tb/sv/perlin_noise_slice_eval_core_chk.sv
tb/sv/perlin_noise_slice_eval_core_tb.sv
